[rtl/mbps_pkg.sv]
// mbps_pkg: shared types, constants and helpers for the masked byte pattern scanner
// no dependencies; imported by mbps_cell, masked_byte_pattern_scanner and the bench files
package mbps_pkg;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_OFFSET_BITS       = 32;

    // configured pattern bytes and care bits; positions beyond these are wildcards
    localparam int PATTERN_SLOTS = 16;
    localparam int SLOT_W        = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int TOTAL_W       = 32;
    localparam int ADDR_W        = 64;

    localparam logic [PATTERN_SLOTS-1:0] CARE_MASK_RESET = '1;
    localparam logic [4:0]               LENGTH_RESET    = 5'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_CARE_MASK    = 3'd2,
        CFG_LENGTH       = 3'd3,
        CFG_BASE_ADDR    = 3'd4,
        CFG_REPORT_ALL   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [PATTERN_SLOTS*8-1:0] pattern;
        logic [PATTERN_SLOTS-1:0]   care;
    } pattern_cfg_t;

    function automatic logic [7:0] pattern_byte(input logic [PATTERN_SLOTS*8-1:0] pattern,
                                                input logic [SLOT_W-1:0] idx);
        return pattern[idx*8 +: 8];
    endfunction

endpackage

[rtl/mbps_cell.sv]
// mbps_cell: one window position of the scanner chain, holds a byte and
// compares the byte of its age against the matching pattern byte; uses mbps_pkg
module mbps_cell #(
    parameter int AGE   = 0,
    parameter int LEN_W = 5
) (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  mbps_pkg::pattern_cfg_t pat,
    input  logic [LEN_W-1:0]      len,
    input  logic [7:0]            byte_in,
    output logic [7:0]            byte_out,
    output logic                  mismatch
);
    import mbps_pkg::*;

    logic [7:0]        byte_reg;
    logic              active;
    logic              in_slots;
    logic [LEN_W-1:0]  k;
    logic [SLOT_W-1:0] idx;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // this age lines up with pattern byte len-1-age when it is inside the window
    always_comb begin
        active   = 32'(len) > 32'(AGE);
        k        = len - LEN_W'(AGE + 1);
        in_slots = 32'(k) < 32'(PATTERN_SLOTS);
        idx      = SLOT_W'(k);
        mismatch = active && in_slots && pat.care[idx]
                   && (byte_in != pattern_byte(pat.pattern, idx));
    end

endmodule

[rtl/masked_byte_pattern_scanner.sv]
// masked_byte_pattern_scanner: streaming masked byte signature search, top level
// depends on mbps_pkg and a chain of mbps_cell instances
//
//  channel   direction  ports                                                  handshake
//  input     in         s_data_byte, s_end_of_region                           s_valid/s_ready
//  result    out        m_match_address, m_is_match, m_matches_so_far, m_last  m_valid/m_ready
//  config    in         cfg_index, cfg_data                                    cfg_write
//
//  one byte accepted per cycle while s_ready is high; the compare over the cell
//  chain and the counter update take the accept cycle, a result register holds
//  the outcome and the output register adds the base address to the match start
//  bytes that cause no result leave nothing in the pipeline
//  s_ready drops only while both result stages are full and m_ready is low
//  aresetn clears configuration to defaults, counters and the result stages
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = mbps_pkg::DEF_OFFSET_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_end_of_region,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbps_pkg::ADDR_W-1:0]       m_match_address,
    output logic                              m_is_match,
    output logic [mbps_pkg::TOTAL_W-1:0]      m_matches_so_far,
    output logic                              m_last,
    input  logic                              cfg_write,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam logic [OFFSET_BITS-1:0] SEEN_MAX  = '1;
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX = '1;

    // configuration
    logic [63:0]              pattern_low_reg;
    logic [63:0]              pattern_high_reg;
    logic [PATTERN_SLOTS-1:0] care_mask_reg;
    logic [4:0]               pattern_length_reg;
    logic [ADDR_W-1:0]        base_address_reg;
    logic                     report_all_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= CARE_MASK_RESET;
            pattern_length_reg <= LENGTH_RESET;
            base_address_reg   <= '0;
            report_all_reg     <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                CFG_CARE_MASK:    care_mask_reg      <= cfg_data[PATTERN_SLOTS-1:0];
                CFG_LENGTH:       pattern_length_reg <= cfg_data[4:0];
                CFG_BASE_ADDR:    base_address_reg   <= cfg_data;
                CFG_REPORT_ALL:   report_all_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // length clamped to 1..MAX_PATTERN_BYTES
    logic [LEN_W-1:0] len_eff;
    always_comb begin
        if (pattern_length_reg == 5'd0) begin
            len_eff = LEN_W'(1);
        end else if (32'(pattern_length_reg) > 32'(MAX_PATTERN_BYTES)) begin
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = LEN_W'(pattern_length_reg);
        end
    end

    pattern_cfg_t pat_cfg;
    assign pat_cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign pat_cfg.care    = care_mask_reg;

    logic s_accept;
    assign s_accept = s_valid && s_ready;

    // cell chain: cell a sees the byte of age a and stores it for cell a+1
    logic [7:0]                   chain [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] mismatch;

    assign chain[0] = s_data_byte;

    for (genvar a = 0; a < MAX_PATTERN_BYTES; a++) begin : g_cell
        if (a < MAX_PATTERN_BYTES - 1) begin : g_mid
            mbps_cell #(.AGE(a), .LEN_W(LEN_W)) u_cell (
                .aclk     (aclk),
                .shift_en (s_accept),
                .pat      (pat_cfg),
                .len      (len_eff),
                .byte_in  (chain[a]),
                .byte_out (chain[a+1]),
                .mismatch (mismatch[a])
            );
        end else begin : g_end
            mbps_cell #(.AGE(a), .LEN_W(LEN_W)) u_cell (
                .aclk     (aclk),
                .shift_en (s_accept),
                .pat      (pat_cfg),
                .len      (len_eff),
                .byte_in  (chain[a]),
                .byte_out (),
                .mismatch (mismatch[a])
            );
        end
    end

    // region state
    logic [OFFSET_BITS-1:0] seen_reg, seen_next, seen_inc;
    logic                   found_reg, found_next;
    logic [TOTAL_W-1:0]     total_reg, total_next, total_upd;
    logic                   hit, report, emit;
    logic [OFFSET_BITS-1:0] start;

    always_comb begin
        seen_inc  = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 1'b1;
        hit       = (seen_inc >= OFFSET_BITS'(len_eff)) && !(|mismatch);
        start     = seen_inc - OFFSET_BITS'(len_eff);
        report    = hit && (report_all_reg || !found_reg);
        total_upd = (report && total_reg != TOTAL_MAX) ? total_reg + 1'b1 : total_reg;
        emit      = report || s_end_of_region;

        seen_next  = seen_reg;
        found_next = found_reg;
        total_next = total_reg;
        if (s_accept) begin
            if (s_end_of_region) begin
                seen_next  = '0;
                found_next = 1'b0;
                total_next = '0;
            end else begin
                seen_next  = seen_inc;
                found_next = found_reg || report;
                total_next = total_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            found_reg <= 1'b0;
            total_reg <= '0;
        end else begin
            seen_reg  <= seen_next;
            found_reg <= found_next;
            total_reg <= total_next;
        end
    end

    // result stage, then output stage with the address add
    logic                   a_valid_reg, a_valid_next;
    logic                   a_report_reg;
    logic                   a_last_reg;
    logic [OFFSET_BITS-1:0] a_start_reg;
    logic [TOTAL_W-1:0]     a_total_reg;
    logic                   m_valid_reg, m_valid_next;
    logic                   out_advance;

    assign out_advance = !m_valid_reg || m_ready;
    assign s_ready     = !a_valid_reg || out_advance;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = emit;
        end else if (out_advance) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_advance) begin
            m_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_report_reg <= report;
            a_last_reg   <= s_end_of_region;
            a_start_reg  <= start;
            a_total_reg  <= total_upd;
        end
        if (out_advance && a_valid_reg) begin
            m_match_address  <= a_report_reg ? base_address_reg + ADDR_W'(a_start_reg) : '0;
            m_is_match       <= a_report_reg;
            m_matches_so_far <= a_total_reg;
            m_last           <= a_last_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // a word without last is only ever a match report
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_is_match)
        else $error("non-final word without a match");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_match |-> m_match_address == '0)
        else $error("no-match word carries an address");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_match |-> m_matches_so_far != '0)
        else $error("match word with zero count");

    // region state is cleared after the final byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_end_of_region |=> seen_reg == '0 && total_reg == '0 && !found_reg)
        else $error("region state not cleared after final byte");

endmodule

[bench/scan_result_checker.sv]
`timescale 1ns / 100ps
// scan_result_checker: follows the register port and both word channels of the scanner,
// predicts each result word and compares it with what the scanner gives, field by field
// depends on mbps_pkg for register indexes, reset values and port widths
module scan_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_end_of_region,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [mbps_pkg::ADDR_W-1:0]       m_match_address,
    input  logic                              m_is_match,
    input  logic [mbps_pkg::TOTAL_W-1:0]      m_matches_so_far,
    input  logic                              m_last,
    input  logic                              cfg_write,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int unsigned                       mismatch_count,
    output int unsigned                       pending_words
);
    import mbps_pkg::*;

    localparam int HISTORY_DEPTH = 15;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic               hit;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } scan_result_t;

    logic [63:0]        pat_low_q;
    logic [63:0]        pat_high_q;
    logic [15:0]        care_q;
    logic [4:0]         len_q;
    logic [63:0]        base_q;
    logic               report_all_q;

    logic [7:0]         history_q [HISTORY_DEPTH];
    logic [31:0]        bytes_seen_q;
    logic               already_found_q;
    logic [TOTAL_W-1:0] match_total_q;

    scan_result_t       awaited_results [$];

    initial begin
        mismatch_count = 0;
        pending_words  = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic clear_region;
        bytes_seen_q    = '0;
        already_found_q = 1'b0;
        match_total_q   = '0;
    endtask

    task automatic predict_scan_step(input logic [7:0] now, input logic fin);
        int unsigned  eff_len;
        int unsigned  k;
        int unsigned  age;
        logic [127:0] pattern;
        logic [7:0]   seen_byte;
        logic         hit;
        logic         report;
        logic [31:0]  start;
        scan_result_t res;
        pattern = {pat_high_q, pat_low_q};
        eff_len = (len_q == 0) ? 1 : (len_q > 16) ? 16 : len_q;
        if (bytes_seen_q != '1)
            bytes_seen_q++;
        hit   = 1'b0;
        start = '0;
        if (bytes_seen_q >= eff_len) begin
            hit = 1'b1;
            for (k = 0; k < eff_len; k++) begin
                // pattern byte k lines up with the byte seen eff_len-1-k words ago
                age = eff_len - 1 - k;
                seen_byte = (age == 0) ? now : history_q[age - 1];
                if (care_q[k] && seen_byte != pattern[k*8 +: 8])
                    hit = 1'b0;
            end
            start = bytes_seen_q - eff_len;
        end
        report = hit && (report_all_q || !already_found_q);
        if (report) begin
            already_found_q = 1'b1;
            if (match_total_q != '1)
                match_total_q++;
        end
        if (report || fin) begin
            res.addr  = report ? base_q + {32'd0, start} : '0;
            res.hit   = report;
            res.total = match_total_q;
            res.last  = fin;
            awaited_results = {awaited_results, res};
        end
        for (k = HISTORY_DEPTH - 1; k > 0; k--)
            history_q[k] = history_q[k - 1];
        history_q[0] = now;
        if (fin)
            clear_region();
    endtask

    task automatic check_result_word;
        scan_result_t want;
        if (awaited_results.size() == 0) begin
            flag_mismatch("result word with nothing expected");
        end else begin
            want = awaited_results.pop_front();
            if (m_match_address !== want.addr)
                flag_mismatch($sformatf("match_address %h, expected %h",
                                        m_match_address, want.addr));
            if (m_is_match !== want.hit)
                flag_mismatch($sformatf("is_match %b, expected %b", m_is_match, want.hit));
            if (m_matches_so_far !== want.total)
                flag_mismatch($sformatf("matches_so_far %0d, expected %0d",
                                        m_matches_so_far, want.total));
            if (m_last !== want.last)
                flag_mismatch($sformatf("last %b, expected %b", m_last, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_q    = '0;
            pat_high_q   = '0;
            care_q       = CARE_MASK_RESET;
            len_q        = LENGTH_RESET;
            base_q       = '0;
            report_all_q = 1'b0;
            foreach (history_q[i])
                history_q[i] = '0;
            clear_region();
            awaited_results.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_PATTERN_LOW:  pat_low_q    = cfg_data;
                    CFG_PATTERN_HIGH: pat_high_q   = cfg_data;
                    CFG_CARE_MASK:    care_q       = cfg_data[15:0];
                    CFG_LENGTH:       len_q        = cfg_data[4:0];
                    CFG_BASE_ADDR:    base_q       = cfg_data;
                    CFG_REPORT_ALL:   report_all_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready)
                check_result_word();
            if (s_valid && s_ready)
                predict_scan_step(s_data_byte, s_end_of_region);
        end
        pending_words = awaited_results.size();
    end

endmodule

[bench/masked_byte_pattern_scanner_tb.sv]
`timescale 1ns / 100ps
// masked_byte_pattern_scanner_tb: drives byte words and register writes into the scanner
// with random stalls on both channels; scan_result_checker does the prediction
// depends on mbps_pkg, masked_byte_pattern_scanner and scan_result_checker
module masked_byte_pattern_scanner_tb;
    import mbps_pkg::*;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_data_byte     = '0;
    logic                    s_end_of_region = 1'b0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [ADDR_W-1:0]       m_match_address;
    logic                    m_is_match;
    logic [TOTAL_W-1:0]      m_matches_so_far;
    logic                    m_last;
    logic                    cfg_write       = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0]   cfg_data        = '0;

    int unsigned             mismatch_count;
    int unsigned             pending_words;
    bit                      pacing_on = 1'b1;

    // settings the stimulus is currently shaped for
    logic [63:0]             pat_low    = '0;
    logic [63:0]             pat_high   = '0;
    logic [15:0]             care       = CARE_MASK_RESET;
    logic [4:0]              pat_len    = LENGTH_RESET;
    logic [63:0]             base_addr  = '0;
    logic                    report_all = 1'b0;

    masked_byte_pattern_scanner DUT (.*);

    scan_result_checker checker_i (.*);

    always #1 aclk = ~aclk;

    initial begin
        #400_000;
        $display("simulation failed");
        $finish;
    end

    // result side stalls in bursts
    always @(negedge aclk) begin
        if (pacing_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    task automatic send_scan_byte(input logic [7:0] b, input logic fin);
        if (pacing_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_region <= fin;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_words != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
    endtask

    task automatic program_scanner;
        wait_drained();
        put_reg(CFG_PATTERN_LOW, pat_low);
        put_reg(CFG_PATTERN_HIGH, pat_high);
        put_reg(CFG_CARE_MASK, {48'd0, care});
        put_reg(CFG_LENGTH, {59'd0, pat_len});
        put_reg(CFG_BASE_ADDR, base_addr);
        put_reg(CFG_REPORT_ALL, {63'd0, report_all});
        cfg_write <= 1'b0;
    endtask

    task automatic scan_random_regions(input int unsigned byte_budget);
        int unsigned  sent;
        int unsigned  region_len;
        int unsigned  eff_len;
        int unsigned  pick;
        int unsigned  k;
        int unsigned  spot;
        logic [127:0] pattern;
        logic [7:0]   region_bytes [$];
        sent    = 0;
        pattern = {pat_high, pat_low};
        eff_len = (pat_len == 0) ? 1 : (pat_len > 16) ? 16 : pat_len;
        while (sent < byte_budget) begin
            region_len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60)
                                                     : $urandom_range(1, 24);
            region_bytes.delete();
            while (region_bytes.size() < region_len) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    // planted copy, wildcards random, now and then one byte spoilt
                    for (k = 0; k < eff_len; k++)
                        region_bytes = {region_bytes,
                                        care[k] ? pattern[k*8 +: 8] : 8'($urandom)};
                    if (pick == 5) begin
                        spot = region_bytes.size() - 1 - $urandom_range(0, eff_len - 1);
                        region_bytes[spot] ^= 8'($urandom_range(1, 255));
                    end
                end else if (pick < 8) begin
                    k = $urandom_range(0, 15);
                    region_bytes = {region_bytes, pattern[k*8 +: 8]};
                end else begin
                    region_bytes = {region_bytes, 8'($urandom)};
                end
            end
            foreach (region_bytes[i])
                send_scan_byte(region_bytes[i], i == region_bytes.size() - 1);
            sent += region_bytes.size();
        end
    endtask

    initial begin : stimulus
        int unsigned  phase;
        int unsigned  k;
        logic [127:0] full_pattern;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: single zero byte, first match only
        send_scan_byte(8'h00, 1'b0);
        send_scan_byte(8'hFF, 1'b0);
        send_scan_byte(8'h00, 1'b1);

        // middle byte wildcard; base near the top so the second address wraps
        pat_low    = 64'h0000_0000_0043_5A41;
        pat_high   = '0;
        care       = 16'h0005;
        pat_len    = 5'd3;
        base_addr  = 64'hFFFF_FFFF_FFFF_FFFE;
        report_all = 1'b1;
        program_scanner();
        send_scan_byte(8'h43, 1'b1);
        send_scan_byte(8'h41, 1'b0);
        send_scan_byte(8'h71, 1'b0);
        send_scan_byte(8'h43, 1'b0);
        send_scan_byte(8'h41, 1'b0);
        send_scan_byte(8'h72, 1'b0);
        send_scan_byte(8'h43, 1'b1);

        // zero length acts as one, all wildcards; mode flipped inside the region
        pat_len    = 5'd0;
        care       = '0;
        report_all = 1'b0;
        program_scanner();
        send_scan_byte(8'h5A, 1'b0);
        send_scan_byte(8'hA5, 1'b0);
        report_all = 1'b1;
        program_scanner();
        send_scan_byte(8'h00, 1'b1);

        // oversize length clamps to sixteen; full window closes on the final word
        pat_low    = 64'h0123_4567_89AB_CDEF;
        pat_high   = 64'hFEDC_BA98_7654_3210;
        care       = '1;
        pat_len    = 5'd31;
        report_all = 1'b0;
        program_scanner();
        full_pattern = {pat_high, pat_low};
        for (k = 0; k < 16; k++)
            send_scan_byte(full_pattern[k*8 +: 8], k == 15);

        for (phase = 0; phase < 10; phase++) begin
            pacing_on  = (phase < 8);
            pat_low    = {$urandom, $urandom};
            pat_high   = {$urandom, $urandom};
            care       = 16'($urandom);
            pat_len    = 5'($urandom_range(1, 8));
            base_addr  = {$urandom, $urandom};
            report_all = 1'($urandom);
            case (phase)
                0: begin
                    pat_len    = 5'd16;
                    care       = '1;
                    report_all = 1'b1;
                end
                1: pat_len = 5'd1;
                2: begin
                    pat_len = 5'd0;
                    care    = '0;
                end
                3: pat_len = 5'($urandom_range(17, 31));
                4: base_addr = '1;
                5: begin
                    pat_low  = '0;
                    pat_high = '1;
                end
                6: begin
                    care    = '1;
                    pat_len = 5'd2;
                end
                default: ;
            endcase
            program_scanner();
            if (phase == 4) begin
                // hold the sender until every result word is back
                scan_random_regions(20);
                wait_drained();
                scan_random_regions(20);
            end else begin
                scan_random_regions(40);
            end
        end

        wait_drained();
        repeat (6) @(negedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[masked_byte_pattern_scanner.f]
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_scanner.sv
bench/scan_result_checker.sv
bench/masked_byte_pattern_scanner_tb.sv
